// File: design/rv32ieu_pkg.sv
// shared types and constants for the rv32i execute unit
package rv32ieu_pkg;

    localparam int RegCount = 32;
    localparam int RegIdxW = 5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;
    localparam logic [1:0] ST_UNEXPECTED = 2'd3;

    localparam logic [1:0] REQ_NONE = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [6:0] OP_REG = 7'h33;
    localparam logic [6:0] OP_IMM = 7'h13;
    localparam logic [6:0] OP_LOAD = 7'h03;
    localparam logic [6:0] OP_STORE = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LUI = 7'h37;
    localparam logic [6:0] OP_AUIPC = 7'h17;
    localparam logic [6:0] OP_JAL = 7'h6F;
    localparam logic [6:0] OP_JALR = 7'h67;

    // instruction class decided by the front end
    typedef enum logic [3:0] {
        K_ILLEGAL, K_ALU_R, K_ALU_I, K_LOAD, K_STORE, K_BRANCH,
        K_LUI, K_AUIPC, K_JAL, K_JALR, K_LDATA
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] instr;
        logic [31:0] ldata;
    } qent_t;

endpackage

// File: design/rv32ieu_front.sv
// front end: accepts items, classifies them and fills a two-entry queue
module rv32ieu_front
    import rv32ieu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [31:0] s_instruction,
    input  logic [31:0] s_load_data,
    output logic        q_valid,
    input  logic        q_ready,
    output qent_t       q_data
);
    qent_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic rd_ptr_reg, wr_ptr_reg;
    kind_t kind;
    logic [2:0] f3;
    logic [6:0] f7;
    logic push, pop;

    assign f3 = s_instruction[14:12];
    assign f7 = s_instruction[31:25];

    always_comb begin
        kind = K_ILLEGAL;
        if (s_operation) begin
            kind = K_LDATA;
        end else begin
            unique case (s_instruction[6:0])
                OP_REG: if (f7 == 7'h00 || (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)))
                    kind = K_ALU_R;
                OP_IMM: if ((f3 == 3'd1 && f7 == 7'h00) ||
                            (f3 == 3'd5 && (f7 == 7'h00 || f7 == 7'h20)) ||
                            (f3 != 3'd1 && f3 != 3'd5)) kind = K_ALU_I;
                OP_LOAD: if (f3 != 3'd3 && f3 != 3'd6 && f3 != 3'd7) kind = K_LOAD;
                OP_STORE: if (f3 <= 3'd2) kind = K_STORE;
                OP_BRANCH: if (f3 != 3'd2 && f3 != 3'd3) kind = K_BRANCH;
                OP_LUI: kind = K_LUI;
                OP_AUIPC: kind = K_AUIPC;
                OP_JAL: kind = K_JAL;
                OP_JALR: if (f3 == 3'd0) kind = K_JALR;
                default: kind = K_ILLEGAL;
            endcase
        end
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_data = q_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        else if (pop && !push) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) rd_ptr_reg <= !rd_ptr_reg;
        end
        if (push) q_reg[wr_ptr_reg] <= '{kind: kind, instr: s_instruction, ldata: s_load_data};
    end

    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    a_full_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 || cnt_reg == 2'd0) |-> rd_ptr_reg == wr_ptr_reg)
        else $error("queue pointers disagree with count");
    a_push_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("push lost");
endmodule

// File: design/rv32ieu_back.sv
// back end: register file, pc, execution and the output register
module rv32ieu_back
    import rv32ieu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  qent_t       q_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_next_pc,
    output logic [1:0]  m_mem_request,
    output logic [31:0] m_mem_address,
    output logic [31:0] m_mem_write_data,
    output logic [1:0]  m_mem_size,
    output logic        m_reg_written,
    output logic [4:0]  m_dest_index,
    output logic [31:0] m_dest_value
);
    logic [31:0] rf_reg [RegCount];
    logic [RegCount-1:0] rf_vld_reg;
    logic [31:0] pc_reg;
    logic pend_reg;
    logic [4:0] pdest_reg;
    logic [1:0] psize_reg;
    logic puns_reg;
    logic out_vld_reg;

    logic [1:0] st;
    logic [31:0] npc, addr, wdata, res, a, b, ins, d;
    logic [1:0] req, msz;
    logic wr, written;
    logic [4:0] widx, rd;
    logic [2:0] f3;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u, op2;
    logic take, fire;

    function automatic logic [31:0] rd_rf(input logic [4:0] i,
            input logic [31:0] v, input logic ok);
        logic [31:0] r;
        r = (i == 5'd0 || {1'b0, i} >= 6'(RegCount) || !ok) ? 32'd0 : v;
        return r;
    endfunction

    assign ins = q_data.instr;
    assign rd = ins[11:7];
    assign f3 = ins[14:12];
    assign a = rd_rf(ins[19:15], rf_reg[ins[19:15]], rf_vld_reg[ins[19:15]]);
    assign b = rd_rf(ins[24:20], rf_reg[ins[24:20]], rf_vld_reg[ins[24:20]]);
    assign imm_i = {{20{ins[31]}}, ins[31:20]};
    assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    assign imm_u = {ins[31:12], 12'd0};

    assign q_ready = !out_vld_reg || m_ready;
    assign fire = q_valid && q_ready;

    always_comb begin
        st = ST_OK; npc = pc_reg; req = REQ_NONE; addr = '0; wdata = '0; msz = 2'd0;
        wr = 1'b0; res = '0; widx = rd; take = 1'b0; d = q_data.ldata;
        op2 = (q_data.kind == K_ALU_R) ? b : imm_i;
        if (q_data.kind == K_LDATA) begin
            if (!pend_reg) st = ST_UNEXPECTED;
            else begin
                if (psize_reg == 2'd0) d = puns_reg ? {24'd0, d[7:0]} : {{24{d[7]}}, d[7:0]};
                else if (psize_reg == 2'd1)
                    d = puns_reg ? {16'd0, d[15:0]} : {{16{d[15]}}, d[15:0]};
                wr = 1'b1; res = d; widx = pdest_reg;
            end
        end else if (pend_reg) begin
            st = ST_BUSY;
        end else begin
            npc = pc_reg + 32'd4;
            unique case (q_data.kind)
                K_ALU_R, K_ALU_I: begin
                    wr = 1'b1;
                    unique case (f3)
                        3'd0: res = (q_data.kind == K_ALU_R && ins[30]) ? a - op2 : a + op2;
                        3'd1: res = a << op2[4:0];
                        3'd2: res = {31'd0, $signed(a) < $signed(op2)};
                        3'd3: res = {31'd0, a < op2};
                        3'd4: res = a ^ op2;
                        3'd5: res = ins[30] ? 32'($signed(a) >>> op2[4:0]) : a >> op2[4:0];
                        3'd6: res = a | op2;
                        default: res = a & op2;
                    endcase
                end
                K_LOAD: begin
                    req = REQ_READ; addr = a + imm_i; msz = f3[1:0];
                end
                K_STORE: begin
                    req = REQ_WRITE; addr = a + imm_s; wdata = b; msz = f3[1:0];
                end
                K_BRANCH: begin
                    if (f3[2]) take = f3[1] ? (a < b) : ($signed(a) < $signed(b));
                    else take = (a == b);
                    if (f3[0]) take = !take;
                    if (take) npc = pc_reg + imm_b;
                end
                K_LUI: begin wr = 1'b1; res = imm_u; end
                K_AUIPC: begin wr = 1'b1; res = pc_reg + imm_u; end
                K_JAL: begin wr = 1'b1; res = pc_reg + 32'd4; npc = pc_reg + imm_j; end
                K_JALR: begin
                    wr = 1'b1; res = pc_reg + 32'd4; npc = (a + imm_i) & ~32'd1;
                end
                default: begin st = ST_ILLEGAL; npc = pc_reg; end
            endcase
        end
        written = wr && widx != 5'd0 && {1'b0, widx} < 6'(RegCount);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_vld_reg <= '0;
            pc_reg <= '0;
            pend_reg <= 1'b0;
            pdest_reg <= '0;
            psize_reg <= '0;
            puns_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= fire || (out_vld_reg && !m_ready);
            if (fire) begin
                if (st == ST_OK) begin
                    pc_reg <= npc;
                    if (written) rf_vld_reg[widx] <= 1'b1;
                    if (q_data.kind == K_LDATA) pend_reg <= 1'b0;
                    if (q_data.kind == K_LOAD) begin
                        pend_reg <= 1'b1; pdest_reg <= rd;
                        psize_reg <= f3[1:0]; puns_reg <= f3[2];
                    end
                end
            end
        end
        if (fire) begin
            if (st == ST_OK && written) rf_reg[widx] <= res;
            m_status <= st; m_next_pc <= npc; m_mem_request <= req;
            m_mem_address <= addr; m_mem_write_data <= wdata; m_mem_size <= msz;
            m_reg_written <= written;
            m_dest_index <= written ? widx : 5'd0;
            m_dest_value <= written ? res : 32'd0;
        end
    end

    assign m_valid = out_vld_reg;

    a_x0: assert property (@(posedge aclk) disable iff (!aresetn) !rf_vld_reg[0])
        else $error("x0 written");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_ready) |=> out_vld_reg)
        else $error("result dropped");
    a_pend_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && pend_reg && q_data.kind != K_LDATA) |-> st == ST_BUSY)
        else $error("instruction ran during pending load");
endmodule

// File: design/rv32i_integer_execute_unit.sv
// top level of the rv32i execute unit
// Each item yields one result; a new item can be taken every cycle while the result
// port does not stall. An item passes through a two-entry classify queue and one
// execute stage: it is registered in a queue entry, then executed and registered in
// the output register, which presents the result. While the result port stalls, the
// output register and the two queue entries hold three items before the input stalls.
// Register file reads and writes happen in the execute stage, so back-to-back dependent
// instructions see each other's results.
module rv32i_integer_execute_unit
    import rv32ieu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [31:0] s_instruction,
    input  logic [31:0] s_load_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_next_pc,
    output logic [1:0]  m_mem_request,
    output logic [31:0] m_mem_address,
    output logic [31:0] m_mem_write_data,
    output logic [1:0]  m_mem_size,
    output logic        m_reg_written,
    output logic [4:0]  m_dest_index,
    output logic [31:0] m_dest_value
);
    logic q_valid, q_ready;
    qent_t q_data;

    rv32ieu_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_operation, .s_instruction,
        .s_load_data, .q_valid, .q_ready, .q_data
    );

    rv32ieu_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data, .m_valid, .m_ready,
        .m_status, .m_next_pc, .m_mem_request, .m_mem_address, .m_mem_write_data,
        .m_mem_size, .m_reg_written, .m_dest_index, .m_dest_value
    );
endmodule

// File: verif/rv32ieu_tb_pkg.sv
// instruction field codes shared by the execute unit testbench files
package rv32ieu_tb_pkg;

    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_SLT = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR = 3'd4;
    localparam logic [2:0] F3_SR = 3'd5;
    localparam logic [2:0] F3_OR = 3'd6;
    localparam logic [2:0] F3_AND = 3'd7;

    localparam logic [2:0] F3_BEQ = 3'd0;
    localparam logic [2:0] F3_BNE = 3'd1;
    localparam logic [2:0] F3_BLT = 3'd4;
    localparam logic [2:0] F3_BGE = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_LB = 3'd0;
    localparam logic [2:0] F3_LH = 3'd1;
    localparam logic [2:0] F3_LW = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT = 7'h20;

    localparam logic ITEM_INSTR = 1'b0;
    localparam logic ITEM_LDATA = 1'b1;

endpackage

// File: verif/rv32ieu_checker.sv
// predicts execute unit results from observed transfers and compares them
module rv32ieu_checker
    import rv32ieu_pkg::*;
    import rv32ieu_tb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_operation,
    input  logic [31:0] s_instruction,
    input  logic [31:0] s_load_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [31:0] m_next_pc,
    input  logic [1:0]  m_mem_request,
    input  logic [31:0] m_mem_address,
    input  logic [31:0] m_mem_write_data,
    input  logic [1:0]  m_mem_size,
    input  logic        m_reg_written,
    input  logic [4:0]  m_dest_index,
    input  logic [31:0] m_dest_value,
    output int          errors,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] npc;
        logic [1:0]  req;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [1:0]  size;
        logic        wr;
        logic [4:0]  idx;
        logic [31:0] val;
    } exec_result_t;

    exec_result_t expected_results[$];

    logic [31:0] regs [32];
    logic [31:0] pc;
    logic        ld_busy;
    logic [4:0]  ld_dest;
    logic [1:0]  ld_size;
    logic        ld_unsigned;

    function automatic logic [31:0] read_reg(logic [4:0] i);
        return (i == 0 || i >= RegCount) ? 32'd0 : regs[i];
    endfunction

    function automatic logic [31:0] alu_op(logic [2:0] f3, logic alt, logic [31:0] a,
                                           logic [31:0] b);
        case (f3)
            F3_ADD:  return alt ? a - b : a + b;
            F3_SLL:  return a << b[4:0];
            F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
            F3_SLTU: return {31'd0, a < b};
            F3_XOR:  return a ^ b;
            F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            F3_OR:   return a | b;
            default: return a & b;
        endcase
    endfunction

    // write-back helper: sets wr/idx/val of the result when the write lands
    task automatic write_reg(logic [4:0] i, logic [31:0] v, inout exec_result_t r);
        if (i != 0 && i < RegCount) begin
            regs[i] = v;
            r.wr = 1'b1;
            r.idx = i;
            r.val = v;
        end
    endtask

    task automatic execute_item(logic op, logic [31:0] ins, logic [31:0] ld);
        exec_result_t r;
        logic [6:0] opc;
        logic [4:0] rd;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, seq, npc, res, d;
        logic ok, wr, taken;
        r = '{default: '0};
        r.status = ST_OK;
        npc = pc;
        if (op == ITEM_LDATA) begin
            if (!ld_busy) begin
                r.status = ST_UNEXPECTED;
            end else begin
                d = ld;
                if (ld_size == SZ_BYTE) d = ld_unsigned ? {24'd0, ld[7:0]}
                                                         : {{24{ld[7]}}, ld[7:0]};
                else if (ld_size == SZ_HALF) d = ld_unsigned ? {16'd0, ld[15:0]}
                                                              : {{16{ld[15]}}, ld[15:0]};
                write_reg(ld_dest, d, r);
                ld_busy = 1'b0;
            end
        end else if (ld_busy) begin
            r.status = ST_BUSY;
        end else begin
            opc = ins[6:0];
            rd = ins[11:7];
            f3 = ins[14:12];
            f7 = ins[31:25];
            a = read_reg(ins[19:15]);
            b = read_reg(ins[24:20]);
            imm_i = {{20{ins[31]}}, ins[31:20]};
            imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
            imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
            imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
            seq = pc + 32'd4;
            npc = seq;
            ok = 1'b1;
            wr = 1'b0;
            res = '0;
            case (opc)
                OP_REG: begin
                    if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
                        res = alu_op(f3, f7 == F7_ALT, a, b);
                        wr = 1'b1;
                    end else ok = 1'b0;
                end
                OP_IMM: begin
                    if (f3 == F3_SLL && f7 != F7_BASE) ok = 1'b0;
                    else if (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT) ok = 1'b0;
                    else if (f3 == F3_SLL || f3 == F3_SR) begin
                        res = alu_op(f3, ins[30], a, {27'd0, ins[24:20]});
                        wr = 1'b1;
                    end else begin
                        res = alu_op(f3, 1'b0, a, imm_i);
                        wr = 1'b1;
                    end
                end
                OP_LOAD: begin
                    if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) ok = 1'b0;
                    else begin
                        r.req = REQ_READ;
                        r.addr = a + imm_i;
                        r.size = f3[1:0];
                        ld_busy = 1'b1;
                        ld_dest = rd;
                        ld_size = f3[1:0];
                        ld_unsigned = f3[2];
                    end
                end
                OP_STORE: begin
                    if (f3 > F3_LW) ok = 1'b0;
                    else begin
                        r.req = REQ_WRITE;
                        r.addr = a + imm_s;
                        r.wdata = b;
                        r.size = f3[1:0];
                    end
                end
                OP_BRANCH: begin
                    if (f3 == 3'd2 || f3 == 3'd3) ok = 1'b0;
                    else begin
                        if (f3[2]) taken = f3[1] ? (a < b) : ($signed(a) < $signed(b));
                        else taken = (a == b);
                        if (f3[0]) taken = !taken;
                        if (taken) npc = pc + imm_b;
                    end
                end
                OP_LUI: begin
                    res = {ins[31:12], 12'd0};
                    wr = 1'b1;
                end
                OP_AUIPC: begin
                    res = pc + {ins[31:12], 12'd0};
                    wr = 1'b1;
                end
                OP_JAL: begin
                    res = seq;
                    wr = 1'b1;
                    npc = pc + imm_j;
                end
                OP_JALR: begin
                    if (f3 != 3'd0) ok = 1'b0;
                    else begin
                        res = seq;
                        wr = 1'b1;
                        npc = (a + imm_i) & ~32'd1;
                    end
                end
                default: ok = 1'b0;
            endcase
            if (!ok) begin
                r.status = ST_ILLEGAL;
                npc = pc;
                r.req = REQ_NONE;
                r.addr = '0;
                r.wdata = '0;
                r.size = '0;
            end else begin
                if (wr) write_reg(rd, res, r);
                pc = npc;
            end
        end
        r.npc = npc;
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        exec_result_t e;
        if (!aresetn) begin
            foreach (regs[i]) regs[i] = '0;
            pc = '0;
            ld_busy = 1'b0;
            ld_dest = '0;
            ld_size = '0;
            ld_unsigned = 1'b0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", 32'd0, 32'd0);
                end else begin
                    e = expected_results.pop_front();
                    if (m_status !== e.status) report_mismatch("status", m_status, e.status);
                    if (m_next_pc !== e.npc) report_mismatch("next_pc", m_next_pc, e.npc);
                    if (m_mem_request !== e.req)
                        report_mismatch("mem_request", m_mem_request, e.req);
                    if (m_mem_address !== e.addr)
                        report_mismatch("mem_address", m_mem_address, e.addr);
                    if (m_mem_write_data !== e.wdata)
                        report_mismatch("mem_write_data", m_mem_write_data, e.wdata);
                    if (m_mem_size !== e.size) report_mismatch("mem_size", m_mem_size, e.size);
                    if (m_reg_written !== e.wr)
                        report_mismatch("reg_written", m_reg_written, e.wr);
                    if (m_dest_index !== e.idx)
                        report_mismatch("dest_index", m_dest_index, e.idx);
                    if (m_dest_value !== e.val)
                        report_mismatch("dest_value", m_dest_value, e.val);
                end
            end
            if (s_valid && s_ready) execute_item(s_operation, s_instruction, s_load_data);
        end
        outstanding = expected_results.size();
    end

    initial begin
        errors = 0;
        outstanding = 0;
    end

endmodule

// File: verif/rv32i_integer_execute_unit_tb.sv
// stimulus and verdict for the rv32i execute unit
module rv32i_integer_execute_unit_tb;
    import rv32ieu_pkg::*;
    import rv32ieu_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 256;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_operation;
    logic [31:0] s_instruction;
    logic [31:0] s_load_data;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [31:0] m_next_pc;
    logic [1:0]  m_mem_request;
    logic [31:0] m_mem_address;
    logic [31:0] m_mem_write_data;
    logic [1:0]  m_mem_size;
    logic        m_reg_written;
    logic [4:0]  m_dest_index;
    logic [31:0] m_dest_value;

    int errors;
    int outstanding;
    int cycles;
    int idle_pct;
    int stall_pct;
    logic hold_rx;
    logic load_waiting;

    rv32i_integer_execute_unit DUT (.*);
    rv32ieu_checker checker_i (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("rv32i_integer_execute_unit test failed");
            $finish;
        end
    end

    always @(negedge aclk) m_ready = hold_rx ? 1'b0 : ($urandom_range(99) >= stall_pct);

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OP_REG};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    // mostly a few low registers so results feed each other
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(6));
    endfunction

    task automatic send_item(logic op, logic [31:0] ins, logic [31:0] ld);
        logic [2:0] f3;
        if ($urandom_range(99) < idle_pct) repeat ($urandom_range(1, 4)) @(negedge aclk);
        s_operation = op;
        s_instruction = ins;
        s_load_data = ld;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
        f3 = ins[14:12];
        if (op == ITEM_LDATA) load_waiting = 1'b0;
        else if (!load_waiting && ins[6:0] == OP_LOAD && f3 != 3'd3 && f3 < 3'd6)
            load_waiting = 1'b1;
    endtask

    function automatic logic [31:0] random_legal_instr();
        logic [2:0] f3;
        logic [2:0] ld_f3 [5] = '{F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU};
        logic [2:0] br_f3 [6] = '{F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU};
        f3 = 3'($urandom_range(7));
        case ($urandom_range(10))
            0: return enc_r((f3 == F3_ADD || f3 == F3_SR) && $urandom_range(1) ? F7_ALT : F7_BASE,
                            pick_reg(), pick_reg(), f3, pick_reg());
            1: return enc_i(12'($urandom), pick_reg(), (f3 == F3_SLL || f3 == F3_SR) ? F3_ADD : f3,
                            pick_reg(), OP_IMM);
            2: return enc_i({($urandom_range(1) ? F7_ALT : F7_BASE), 5'($urandom)}, pick_reg(),
                            $urandom_range(1) ? F3_SR : F3_SLL, pick_reg(), OP_IMM);
            3: return enc_i(12'($urandom), pick_reg(), ld_f3[$urandom_range(4)], pick_reg(),
                            OP_LOAD);
            4: return enc_s(12'($urandom), pick_reg(), pick_reg(), 3'($urandom_range(2)));
            5: return enc_b(13'($urandom), pick_reg(), pick_reg(), br_f3[$urandom_range(5)]);
            6: return {20'($urandom), pick_reg(), OP_LUI};
            7: return {20'($urandom), pick_reg(), OP_AUIPC};
            8: return enc_j(21'($urandom), pick_reg());
            9: return enc_i(12'($urandom), pick_reg(), F3_ADD, pick_reg(), OP_JALR);
            default: return {7'($urandom), 18'($urandom), OP_REG} | 32'h0200_0000;
        endcase
    endfunction

    task automatic send_random();
        int r;
        r = $urandom_range(99);
        if (load_waiting) begin
            if (r < 85) send_item(ITEM_LDATA, $urandom, $urandom);
            else send_item(ITEM_INSTR, random_legal_instr(), $urandom);
        end else if (r < 4) begin
            send_item(ITEM_LDATA, $urandom, $urandom);
        end else if (r < 9) begin
            send_item(ITEM_INSTR, $urandom, $urandom);
        end else begin
            send_item(ITEM_INSTR, random_legal_instr(), $urandom);
        end
    endtask

    task automatic wait_drained();
        while (outstanding != 0) @(negedge aclk);
    endtask

    initial begin
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_rx = 1'b0;
        load_waiting = 1'b0;
        s_valid = 1'b0;
        s_operation = ITEM_INSTR;
        s_instruction = '0;
        s_load_data = '0;
        m_ready = 1'b0;
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: register setup, all reg-reg alu forms, immediate edges
        send_item(ITEM_LDATA, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(ITEM_INSTR, {20'h80000, 5'd1, OP_LUI}, '0);
        send_item(ITEM_INSTR, enc_i(12'hFFF, 5'd0, F3_ADD, 5'd2, OP_IMM), '0);
        send_item(ITEM_INSTR, enc_i(12'h7FF, 5'd2, F3_XOR, 5'd3, OP_IMM), '0);
        for (int f = 0; f < 8; f++)
            send_item(ITEM_INSTR, enc_r(F7_BASE, 5'd2, 5'd1, 3'(f), 5'(4 + f)), '0);
        send_item(ITEM_INSTR, enc_r(F7_ALT, 5'd2, 5'd1, F3_ADD, 5'd12), '0);
        send_item(ITEM_INSTR, enc_r(F7_ALT, 5'd3, 5'd1, F3_SR, 5'd13), '0);
        send_item(ITEM_INSTR, enc_r(F7_ALT, 5'd2, 5'd1, F3_OR, 5'd13), '0);
        send_item(ITEM_INSTR, enc_i({F7_ALT, 5'd31}, 5'd1, F3_SR, 5'd14, OP_IMM), '0);
        send_item(ITEM_INSTR, enc_i({F7_ALT, 5'd1}, 5'd1, F3_SLL, 5'd14, OP_IMM), '0);
        send_item(ITEM_INSTR, enc_i(12'h800, 5'd1, F3_LB, 5'd15, OP_LOAD), '0);
        send_item(ITEM_INSTR, enc_r(F7_BASE, 5'd1, 5'd1, F3_ADD, 5'd16), '0);
        send_item(ITEM_LDATA, '0, 32'h0000_0080);
        send_item(ITEM_INSTR, enc_i(12'h7FF, 5'd2, F3_LHU, 5'd0, OP_LOAD), '0);
        send_item(ITEM_LDATA, '0, 32'hFFFF_8000);
        send_item(ITEM_INSTR, enc_s(12'h800, 5'd2, 5'd1, F3_LW), '0);
        send_item(ITEM_INSTR, enc_b(13'h1000, 5'd2, 5'd1, F3_BLT), '0);
        send_item(ITEM_INSTR, enc_j(21'h0FFFFE, 5'd31), '0);
        send_item(ITEM_INSTR, enc_i(12'hFFF, 5'd2, F3_ADD, 5'd17, OP_JALR), '0);
        send_item(ITEM_INSTR, {20'hFFFFF, 5'd18, OP_AUIPC}, '0);
        send_item(ITEM_INSTR, 32'hFFFF_FFFF, '0);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 64 : 21) : 0;
            stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 64 : 21) : 0;
            if (phase == 0) begin
                // long receiver hold-off so the unit backs up into its input
                fork
                    begin
                        hold_rx = 1'b1;
                        repeat (150) @(posedge aclk);
                        @(negedge aclk);
                        hold_rx = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) wait_drained();
                send_random();
            end
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (errors == 0 && outstanding == 0) begin
            $display("rv32i_integer_execute_unit test passed");
        end else begin
            $display("rv32i_integer_execute_unit test failed");
        end
        $finish;
    end

endmodule
